/* rtl/arpc_pkg.sv */
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache with expiry: request codes,
// field widths, the table entry layout and table control strobes.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int DEF_CACHE_ENTRIES = 16;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int TIME_W   = 64;
    localparam int REQ_W    = 2;
    localparam int COUNT_W  = 5;

    // stream widths: input beat carries ip, mac, now, lifetime (208 bits)
    localparam int S_DATA_W = 208;
    // output beat carries mac_out, expired_count (53 bits, padded to 56)
    localparam int M_DATA_W = 56;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_LEARN  = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_EXPIRE = 2'd2
    } t_req_type;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] expiry;
    } t_entry;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
    } t_tbl_ctl;

endpackage

/* rtl/arpc_table.sv */
// ----------------------------------------------------------------------------
// arpc_table
// Entry store of the cache: one memory of ip/mac/expiry words with a single
// write port and a registered read port, plus per-entry valid flops.
// ----------------------------------------------------------------------------
module arpc_table #(
    parameter int CACHE_ENTRIES = arpc_pkg::DEF_CACHE_ENTRIES,
    parameter int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  arpc_pkg::t_tbl_ctl i_ctl,
    input  logic [IDX_W-1:0]  i_rd_addr,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  arpc_pkg::t_entry  i_wr_entry,
    input  logic [IDX_W-1:0]  i_clr_addr,
    output arpc_pkg::t_entry  o_rd_entry,
    output logic              o_rd_valid
);
    import arpc_pkg::*;

    t_entry                   r_mem [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] r_valid;
    t_entry                   r_rd_entry;
    logic                     r_rd_valid;

    // write and read the entry memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_ctl.rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    // set valid on write, drop it on clear, sample it with the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.clr_en) begin
                r_valid[i_clr_addr] <= 1'b0;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_valid = r_rd_valid;

endmodule

/* rtl/arpc_seq.sv */
// ----------------------------------------------------------------------------
// arpc_seq
// Request sequencer: walks the table one entry per cycle through a shared
// compare unit (address match, expiry test, oldest tracking), then writes
// the learned entry and forms the result beat.
// ----------------------------------------------------------------------------
module arpc_seq #(
    parameter int CACHE_ENTRIES = arpc_pkg::DEF_CACHE_ENTRIES,
    parameter int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1,
    parameter int CNT_W         = $clog2(CACHE_ENTRIES + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request side
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  logic [arpc_pkg::REQ_W-1:0]   i_req_type,
    input  logic [arpc_pkg::IP_W-1:0]    i_ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0]   i_mac_in,
    input  logic [arpc_pkg::TIME_W-1:0]  i_now_time,
    input  logic [arpc_pkg::TIME_W-1:0]  i_lifetime,
    // result side
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic                         o_status,
    output logic [arpc_pkg::MAC_W-1:0]   o_mac_out,
    output logic [arpc_pkg::COUNT_W-1:0] o_expired_count,
    // table port
    output arpc_pkg::t_tbl_ctl           o_ctl,
    output logic [IDX_W-1:0]             o_rd_addr,
    output logic [IDX_W-1:0]             o_wr_addr,
    output arpc_pkg::t_entry             o_wr_entry,
    output logic [IDX_W-1:0]             o_clr_addr,
    input  arpc_pkg::t_entry             i_rd_entry,
    input  logic                         i_rd_valid
);
    import arpc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN,
        ST_OUT
    } t_state;

    t_state              r_state;
    logic [REQ_W-1:0]    r_req;
    logic [IP_W-1:0]     r_ip;
    logic [MAC_W-1:0]    r_mac;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_life;
    logic                r_bad;
    logic [CNT_W-1:0]    r_rd_cnt;
    logic                r_chk_vld;
    logic [IDX_W-1:0]    r_chk_idx;
    logic                r_found;
    logic [IDX_W-1:0]    r_pick;
    logic [IDX_W-1:0]    r_oldest;
    logic [TIME_W-1:0]   r_oldest_exp;
    logic [MAC_W-1:0]    r_hit_mac;
    logic [COUNT_W-1:0]  r_count;
    logic                r_o_valid;
    logic                r_o_status;
    logic [MAC_W-1:0]    r_o_mac;
    logic [COUNT_W-1:0]  r_o_count;

    logic                rd_more;
    logic                ip_eq;
    logic                expd;
    logic                older;
    logic                eval;
    logic [TIME_W:0]     exp_sum;
    logic                learn_wr;

    // shared compare unit on the entry under test
    assign ip_eq = (i_rd_entry.ip == r_ip) && (r_ip != '0);
    assign expd  = (i_rd_entry.expiry <= r_now);
    assign older = (i_rd_entry.expiry < r_oldest_exp);
    assign eval  = (r_state == ST_SCAN) && r_chk_vld;

    // issue one read per cycle while entries remain
    assign rd_more = (r_rd_cnt < CNT_W'(CACHE_ENTRIES));

    // saturating expiry for a learned entry
    assign exp_sum  = {1'b0, r_now} + {1'b0, r_life};
    assign learn_wr = (r_state == ST_FIN) && (r_req == REQ_LEARN) && !r_bad;

    // drive table strobes and addresses
    always_comb begin
        o_ctl.rd_en  = (r_state == ST_SCAN) && rd_more;
        o_ctl.wr_en  = learn_wr;
        o_ctl.clr_en = eval && (r_req == REQ_EXPIRE) && i_rd_valid && expd;
    end
    assign o_rd_addr         = r_rd_cnt[IDX_W-1:0];
    assign o_wr_addr         = r_found ? r_pick : r_oldest;
    assign o_clr_addr        = r_chk_idx;
    assign o_wr_entry.ip     = r_ip;
    assign o_wr_entry.mac    = r_mac;
    assign o_wr_entry.expiry = exp_sum[TIME_W] ? TIME_MAX : exp_sum[TIME_W-1:0];

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_chk_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req_valid) begin
                        r_req        <= i_req_type;
                        r_ip         <= i_ip_addr;
                        r_mac        <= i_mac_in;
                        r_now        <= i_now_time;
                        r_life       <= i_lifetime;
                        r_bad        <= (i_ip_addr == '0) || (i_lifetime == '0);
                        r_rd_cnt     <= '0;
                        r_chk_vld    <= 1'b0;
                        r_found      <= 1'b0;
                        r_pick       <= '0;
                        r_oldest     <= '0;
                        r_oldest_exp <= TIME_MAX;
                        r_hit_mac    <= '0;
                        r_count      <= '0;
                        r_state      <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // advance the read pointer, track which entry returns next
                    r_chk_vld <= rd_more;
                    r_chk_idx <= r_rd_cnt[IDX_W-1:0];
                    if (rd_more) begin
                        r_rd_cnt <= r_rd_cnt + 1'b1;
                    end
                    // evaluate the entry read last cycle
                    if (eval) begin
                        unique case (r_req)
                            REQ_LEARN: begin
                                if (!r_found) begin
                                    if (!i_rd_valid || ip_eq || expd) begin
                                        r_found <= 1'b1;
                                        r_pick  <= r_chk_idx;
                                    end else if (older) begin
                                        r_oldest     <= r_chk_idx;
                                        r_oldest_exp <= i_rd_entry.expiry;
                                    end
                                end
                            end
                            REQ_LOOKUP: begin
                                if (!r_found && i_rd_valid && ip_eq && !expd) begin
                                    r_found   <= 1'b1;
                                    r_hit_mac <= i_rd_entry.mac;
                                end
                            end
                            REQ_EXPIRE: begin
                                if (i_rd_valid && expd && (r_count != COUNT_MAX)) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (!rd_more && !r_chk_vld) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // form the result beat
                    r_o_valid  <= 1'b1;
                    r_o_mac    <= '0;
                    r_o_count  <= '0;
                    r_o_status <= 1'b1;
                    unique case (r_req)
                        REQ_LEARN: begin
                            r_o_status <= r_bad;
                        end
                        REQ_LOOKUP: begin
                            r_o_status <= !r_found;
                            r_o_mac    <= r_hit_mac;
                        end
                        REQ_EXPIRE: begin
                            r_o_status <= 1'b0;
                            r_o_count  <= r_count;
                        end
                        default: begin
                        end
                    endcase
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // hold the beat until taken
                    if (i_res_ready) begin
                        r_o_valid <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready     = (r_state == ST_IDLE);
    assign o_res_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_mac_out       = r_o_mac;
    assign o_expired_count = r_o_count;

endmodule

/* rtl/arp_cache_with_expiry.sv */
// ----------------------------------------------------------------------------
// arp_cache_with_expiry
// The sequencer serves one request at a time: a new request is taken only
// after the result beat of the last one has been taken.
// The result beat comes from the table walk: one entry read per cycle
// through the single registered read port, then a drain step while the
// last read returns, then a step that forms the result.
// Reset (synchronous, active low) clears all valid marks and the sequencer.
// ----------------------------------------------------------------------------
module arp_cache_with_expiry #(
    parameter int CACHE_ENTRIES = arpc_pkg::DEF_CACHE_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: ip_addr[31:0], mac_in[79:32], now_time[143:80], lifetime[207:144]
    input  logic [arpc_pkg::S_DATA_W-1:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [arpc_pkg::REQ_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: mac_out[47:0], expired_count[52:48], zero pad[55:53]
    output logic [arpc_pkg::M_DATA_W-1:0] m_axis_tdata,
    // tuser: status[0]
    output logic                          m_axis_tuser
);
    import arpc_pkg::*;

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    t_tbl_ctl           ctl;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   clr_addr;
    t_entry             wr_entry;
    t_entry             rd_entry;
    logic               rd_valid;
    logic [MAC_W-1:0]   mac_out;
    logic [COUNT_W-1:0] expired_count;

    arpc_seq #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (s_axis_tvalid),
        .o_req_ready     (s_axis_tready),
        .i_req_type      (s_axis_tuser),
        .i_ip_addr       (s_axis_tdata[31:0]),
        .i_mac_in        (s_axis_tdata[79:32]),
        .i_now_time      (s_axis_tdata[143:80]),
        .i_lifetime      (s_axis_tdata[207:144]),
        .o_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .o_status        (m_axis_tuser),
        .o_mac_out       (mac_out),
        .o_expired_count (expired_count),
        .o_ctl           (ctl),
        .o_rd_addr       (rd_addr),
        .o_wr_addr       (wr_addr),
        .o_wr_entry      (wr_entry),
        .o_clr_addr      (clr_addr),
        .i_rd_entry      (rd_entry),
        .i_rd_valid      (rd_valid)
    );

    arpc_table #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry),
        .i_clr_addr (clr_addr),
        .o_rd_entry (rd_entry),
        .o_rd_valid (rd_valid)
    );

    // pack the result beat
    assign m_axis_tdata = {3'b000, expired_count, mac_out};

endmodule

/* rtl/arpc_chk.sv */
// ----------------------------------------------------------------------------
// arpc_chk
// Port-level checks of the ARP cache: result beat stability, one request in
// flight, and consistency of status with the result payload.
// ----------------------------------------------------------------------------
module arpc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [arpc_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);
    import arpc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // no new request while the previous one is busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
        else $error("request taken while busy");

    // a pending result blocks the request side
    a_one_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request side open with a result pending");

    // a hit MAC or a sweep count only comes with success status
    a_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[52:0] != '0) |-> !m_axis_tuser)
        else $error("payload set on a failed request");

    // reset empties the result side
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind arp_cache_with_expiry arpc_chk u_arpc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/arp_cache_with_expiry_tb.sv */
// ----------------------------------------------------------------------------
// arp_cache_with_expiry_tb
// Self-checking bench for the ARP cache with expiry. A driver streams learn,
// lookup, sweep and unused requests from a queue; each accepted beat is run
// through a cycle-free copy of the table to predict its reply. A monitor
// checks every reply beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module arp_cache_with_expiry_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import arpc_pkg::*;

    localparam int N_SLOTS = DEF_CACHE_ENTRIES;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int N_RANDOM = 550;
    localparam int HOLD_CYCLES = 500;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] life;
    } arp_req_t;

    typedef struct {
        logic               status;
        logic [MAC_W-1:0]   mac;
        logic [COUNT_W-1:0] count;
    } arp_reply_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic [REQ_W-1:0]    s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    // shadow copy of the cache
    logic              slot_valid [N_SLOTS];
    logic [IP_W-1:0]   slot_ip    [N_SLOTS];
    logic [MAC_W-1:0]  slot_mac   [N_SLOTS];
    logic [TIME_W-1:0] slot_expiry[N_SLOTS];

    arp_req_t   pending_reqs[$];
    arp_reply_t due_replies[$];
    arp_req_t   drv_req;
    int         sent_cnt = 0;
    int         recv_cnt = 0;
    int         fail_cnt = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    arp_cache_with_expiry #(
        .CACHE_ENTRIES(N_SLOTS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        // tdata: ip_addr, mac_in, now_time, lifetime (lowest bit up)
        .s_axis_tdata (s_axis_tdata),
        // tuser: req_type
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // tdata: mac_out, expired_count, zero pad (lowest bit up)
        .m_axis_tdata (m_axis_tdata),
        // tuser: status
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the shadow cache and return the reply it earns
    function automatic arp_reply_t serve_request(arp_req_t rq);
        arp_reply_t       rp;
        int               pick;
        int               oldest;
        logic [TIME_W-1:0] oldest_exp;
        logic [TIME_W:0]  sum;
        rp.status = 1'b1;
        rp.mac    = '0;
        rp.count  = '0;
        case (rq.req)
            REQ_LEARN: begin
                if (rq.ip != '0 && rq.life != '0) begin
                    pick = -1;
                    oldest = 0;
                    oldest_exp = TIME_MAX;
                    for (int i = 0; i < N_SLOTS; i++) begin
                        if (pick < 0) begin
                            if (slot_valid[i] && slot_ip[i] == rq.ip) begin
                                pick = i;
                            end else if (!slot_valid[i] || slot_expiry[i] <= rq.now) begin
                                pick = i;
                            end else if (slot_expiry[i] < oldest_exp) begin
                                oldest_exp = slot_expiry[i];
                                oldest = i;
                            end
                        end
                    end
                    // no free, matching or stale slot: evict the earliest expiry
                    if (pick < 0) pick = oldest;
                    sum = {1'b0, rq.now} + {1'b0, rq.life};
                    slot_ip[pick]     = rq.ip;
                    slot_mac[pick]    = rq.mac;
                    slot_expiry[pick] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                    slot_valid[pick]  = 1'b1;
                    rp.status = 1'b0;
                end
            end
            REQ_LOOKUP: begin
                if (rq.ip != '0) begin
                    for (int i = 0; i < N_SLOTS; i++) begin
                        if (rp.status && slot_valid[i] && slot_ip[i] == rq.ip &&
                            slot_expiry[i] > rq.now) begin
                            rp.mac = slot_mac[i];
                            rp.status = 1'b0;
                        end
                    end
                end
            end
            REQ_EXPIRE: begin
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (slot_valid[i] && slot_expiry[i] <= rq.now) begin
                        slot_valid[i] = 1'b0;
                        if (rp.count != COUNT_MAX) rp.count++;
                    end
                end
                rp.status = 1'b0;
            end
            default: ;
        endcase
        return rp;
    endfunction

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [MAC_W-1:0] rand48();
        logic [31:0] hi;
        hi = $urandom;
        return {hi[15:0], $urandom};
    endfunction

    task automatic queue_req(logic [REQ_W-1:0] req, logic [IP_W-1:0] ip,
                             logic [MAC_W-1:0] mac, logic [TIME_W-1:0] now,
                             logic [TIME_W-1:0] life);
        arp_req_t rq;
        rq.req  = req;
        rq.ip   = ip;
        rq.mac  = mac;
        rq.now  = now;
        rq.life = life;
        pending_reqs.push_back(rq);
    endtask

    // Driver: predict on each accepted beat, then offer the next request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                due_replies.push_back(serve_request(drv_req));
                sent_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() > 0 &&
                    ((sent_cnt >= 300 && sent_cnt < 400) || $urandom_range(99) >= 13)) begin
                    drv_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {drv_req.life, drv_req.now, drv_req.mac, drv_req.ip};
                    s_axis_tuser  <= drv_req.req;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted on the falling edge
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && recv_cnt >= 150) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: check each reply beat against the oldest prediction
    always @(posedge i_clk) begin
        arp_reply_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                recv_cnt++;
                if (due_replies.size() == 0) begin
                    $error("reply beat with no request outstanding");
                    fail_cnt++;
                end else begin
                    want = due_replies.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[MAC_W-1:0] !== want.mac) begin
                        $error("mac_out: expected %012h, actual %012h",
                               want.mac, m_axis_tdata[MAC_W-1:0]);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[MAC_W+COUNT_W-1:MAC_W] !== want.count) begin
                        $error("expired_count: expected %0d, actual %0d",
                               want.count, m_axis_tdata[MAC_W+COUNT_W-1:MAC_W]);
                        fail_cnt++;
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) &&
                             ((recv_cnt >= 300 && recv_cnt < 400) || $urandom_range(99) >= 13);
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic [TIME_W-1:0] ticks;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] life;
        logic [IP_W-1:0]   ip;
        int                n_rand;
        int                burst;
        int                pick;

        for (int i = 0; i < N_SLOTS; i++) slot_valid[i] = 1'b0;

        // empty table: miss, empty sweep, unused request type
        queue_req(REQ_LOOKUP, 32'h0A00_0001, '0, '0, '0);
        queue_req(REQ_EXPIRE, '0, '0, '0, '0);
        queue_req(REQ_UNUSED, '1, '1, '1, '1);
        // rejected learns: zero address, zero lifetime
        queue_req(REQ_LEARN, '0, 48'h0011_2233_4455, 64'd10, 64'd100);
        queue_req(REQ_LEARN, 32'h0A00_0001, 48'h0011_2233_4455, 64'd10, '0);
        // all-ones fields: expiry saturates
        queue_req(REQ_LEARN, '1, '1, '1, '1);
        queue_req(REQ_LOOKUP, '1, '0, TIME_MAX - 1, '0);
        queue_req(REQ_LOOKUP, '1, '0, TIME_MAX, '0);
        queue_req(REQ_LOOKUP, '0, '0, '0, '0);
        // short-lived entry, hit then expired miss
        queue_req(REQ_LEARN, 32'd1, '0, '0, 64'd1);
        queue_req(REQ_LOOKUP, 32'd1, '0, '0, '0);
        queue_req(REQ_LOOKUP, 32'd1, '0, 64'd1, '0);
        // stale slot reuse, then refresh of the same address
        queue_req(REQ_LEARN, 32'd2, 48'hA5A5_5A5A_0F0F, 64'd1, 64'd10);
        queue_req(REQ_LEARN, 32'd2, 48'h5A5A_A5A5_F0F0, 64'd2, 64'd20);
        queue_req(REQ_LOOKUP, 32'd2, '0, 64'd5, '0);
        queue_req(REQ_EXPIRE, '0, '0, 64'd5, '0);
        queue_req(REQ_EXPIRE, '0, '0, 64'd100, '0);
        queue_req(REQ_LOOKUP, 32'd2, '0, 64'd5, '0);
        // sweep at the end of time clears everything
        queue_req(REQ_EXPIRE, '0, '0, TIME_MAX, '0);
        queue_req(REQ_LOOKUP, '1, '0, '0, '0);

        // random traffic: fill bursts (forcing eviction) and mixed requests
        ticks = TIME_W'($urandom_range(0, 1000));
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            if ($urandom_range(99) < 20) begin
                burst = $urandom_range(16, 20);
                ticks += TIME_W'($urandom_range(0, 20));
                life = TIME_W'($urandom_range(200, 600));
                for (int k = 0; k < burst; k++) begin
                    queue_req(REQ_LEARN, 32'h0A00_0000 | $urandom_range(1, 24), rand48(),
                              ticks, life);
                end
                n_rand += burst;
            end else begin
                burst = $urandom_range(10, 30);
                for (int k = 0; k < burst; k++) begin
                    ticks += TIME_W'($urandom_range(0, 12));
                    now = ($urandom_range(99) < 5) ? rand64() : ticks;
                    pick = $urandom_range(99);
                    if (pick < 5) life = rand64();
                    else if (pick < 8) life = TIME_MAX - TIME_W'($urandom_range(0, 500));
                    else life = TIME_W'($urandom_range(40, 400));
                    ip = ($urandom_range(99) < 8) ? $urandom
                                                  : (32'h0A00_0000 | $urandom_range(1, 24));
                    pick = $urandom_range(99);
                    if (pick < 40)      queue_req(REQ_LEARN, ip, rand48(), now, life);
                    else if (pick < 75) queue_req(REQ_LOOKUP, ip, rand48(), now, rand64());
                    else if (pick < 85) queue_req(REQ_EXPIRE, $urandom, rand48(), now, rand64());
                    else if (pick < 89) queue_req(REQ_UNUSED, $urandom, rand48(), rand64(),
                                                  rand64());
                    else if (pick < 94) queue_req(REQ_LEARN, '0, rand48(), now, life);
                    else                queue_req(REQ_LEARN, ip, rand48(), now, '0);
                end
                n_rand += burst;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all requests accepted, all replies seen, then settle
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || due_replies.size() != 0);
        repeat (2 * N_SLOTS + 8) @(negedge i_clk);

        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
